// File: hw/rtl/fbsc_pkg.sv
`default_nettype none

package fbsc_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  // control line positions
  localparam int unsigned LnLstrb  = 3;
  localparam int unsigned LnEnable = 4;
  localparam int unsigned LnQ6     = 6;
  localparam int unsigned LnQ7     = 7;

  // register select by {q7, q6}
  localparam logic [1:0] QSelData   = 2'b00;
  localparam logic [1:0] QSelStatus = 2'b01;
  localparam logic [1:0] QSelHshk   = 2'b10;
  localparam logic [1:0] QSelLoad   = 2'b11;

  localparam logic [7:0] ModeMask     = 8'h1f;
  localparam logic [5:0] HshkOnes     = 6'h3f;
  localparam logic [7:0] IdleReadByte = 8'hff;
  localparam logic [3:0] BitsPerByte  = 4'd8;
  localparam logic [3:0] ZeroRunMax   = 4'd8;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // input beat fields, last field in the lowest bits
  typedef struct packed {
    logic       disk_bit;
    logic       drive_sense;
    logic [7:0] write_byte;
    logic       odd_lane;
    logic [3:0] reg_index;
  } item_t;

  // result beat fields, last field in the lowest bits
  typedef struct packed {
    logic       write_ended;
    logic       disk_write_valid;
    logic       disk_write_bit;
    logic       drive_strobe;
    logic [7:0] line_state;
    logic [7:0] read_byte;
  } result_t;

  // controller state
  typedef struct packed {
    logic [7:0] control_lines;
    logic [7:0] mode_register;
    logic       no_underrun;
    logic       writing_active;
    logic       wr_hold_full;
    logic [7:0] wr_hold_byte;
    logic [7:0] rd_hold_byte;
    logic [7:0] bit_shifter;
    logic [3:0] write_bits_left;
    logic [3:0] zero_run_count;
  } state_t;

  localparam state_t StateReset = '{
    control_lines:   8'h00,
    mode_register:   8'h00,
    no_underrun:     1'b1,
    writing_active:  1'b0,
    wr_hold_full:    1'b0,
    wr_hold_byte:    8'h00,
    rd_hold_byte:    8'h00,
    bit_shifter:     8'h00,
    write_bits_left: 4'd0,
    zero_run_count:  4'd0
  };

endpackage

`default_nettype wire

// File: hw/rtl/floppy_bit_serial_controller.sv
// an accepted input beat passes through the input register, then the result
// register, which holds while the output stalls
// throughput: one beat per cycle while the output is not stalled; a new beat is taken while a result waits
// reset: rst_ni clears the control lines, holding buffers and shifter and
// sets the no-underrun flag; no beat is held after reset
`default_nettype none

module floppy_bit_serial_controller
  import fbsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // reg_index[3:0], odd_lane[4], write_byte[12:5], drive_sense[13], disk_bit[14]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // read_byte[7:0], line_state[15:8], drive_strobe[16], disk_write_bit[17],
  // disk_write_valid[18], write_ended[19]
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic       in_valid_q, in_valid_d;
  item_t      in_item_q;
  logic [1:0] in_mode_q;
  logic       res_valid_q, res_valid_d;
  result_t    res_q;
  state_t     state_q;
  state_t     state_d;
  result_t    res_d;
  logic       in_beat;
  logic       advance;

  // handshake
  assign advance       = in_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_beat ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign res_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : res_valid_q);

  // per-item update
  fbsc_step u_step (
    .state_i  (state_q),
    .mode_i   (in_mode_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      in_item_q <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
      in_mode_q <= s_axis_tuser;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

endmodule

`default_nettype wire

// File: hw/rtl/fbsc_step.sv
`default_nettype none

module fbsc_step
  import fbsc_pkg::*;
(
  input  state_t      state_i,
  input  logic [1:0]  mode_i,
  input  item_t       item_i,
  output state_t      state_o,
  output result_t     result_o
);

  logic [7:0] lines;
  logic [7:0] line_bit;
  logic [1:0] qsel;
  logic [7:0] shift_src;
  logic [3:0] left_src;
  logic [3:0] zero_inc;
  logic [7:0] shift_in;
  logic       rx_bit;
  logic       is_access;

  always_comb begin
    state_o   = state_i;
    result_o  = '0;
    lines     = state_i.control_lines;
    line_bit  = 8'h01 << item_i.reg_index[3:1];
    qsel      = 2'b00;
    shift_src = state_i.bit_shifter;
    left_src  = state_i.write_bits_left;
    zero_inc  = state_i.zero_run_count + 4'd1;
    shift_in  = '0;
    rx_bit    = item_i.disk_bit;
    is_access = ((mode_i == MODE_READ) || (mode_i == MODE_WRITE)) && item_i.odd_lane;

    if (is_access) begin
      // set or clear one control line
      if (item_i.reg_index[0]) begin
        lines = lines | line_bit;
      end else begin
        lines = lines & ~line_bit;
      end
      state_o.control_lines = lines;
      // q7 low ends any write
      if (!lines[LnQ7]) begin
        state_o.no_underrun = 1'b1;
        if (state_i.writing_active) begin
          state_o.writing_active = 1'b0;
          result_o.write_ended   = 1'b1;
        end
      end
      result_o.drive_strobe = lines[LnLstrb];
      qsel = {lines[LnQ7], lines[LnQ6]};

      if (mode_i == MODE_READ) begin
        // register read
        case (qsel)
          QSelData: begin
            if (lines[LnEnable]) begin
              result_o.read_byte   = state_i.rd_hold_byte;
              state_o.rd_hold_byte = '0;
            end else begin
              result_o.read_byte = IdleReadByte;
            end
          end
          QSelStatus: begin
            result_o.read_byte = {item_i.drive_sense, 1'b0, lines[LnEnable], 5'b0}
                               | (state_i.mode_register & ModeMask);
          end
          QSelHshk: begin
            result_o.read_byte = {~state_i.wr_hold_full, state_o.no_underrun, HshkOnes};
          end
          default: begin
            result_o.read_byte = '0;
          end
        endcase
      end else if (qsel == QSelLoad) begin
        // data or mode load
        if (lines[LnEnable]) begin
          if (!state_o.writing_active) begin
            state_o.writing_active  = 1'b1;
            state_o.write_bits_left = '0;
          end
          state_o.wr_hold_byte = item_i.write_byte;
          state_o.wr_hold_full = 1'b1;
        end else begin
          state_o.mode_register = item_i.write_byte;
        end
      end
    end else if (mode_i == MODE_TICK) begin
      if (state_i.writing_active) begin
        // serialize with underrun check
        if ((state_i.write_bits_left == '0) && !state_i.wr_hold_full) begin
          state_o.no_underrun    = 1'b0;
          state_o.writing_active = 1'b0;
          result_o.write_ended   = 1'b1;
        end else begin
          if (state_i.write_bits_left == '0) begin
            shift_src            = state_i.wr_hold_byte;
            left_src             = BitsPerByte;
            state_o.wr_hold_byte = '0;
            state_o.wr_hold_full = 1'b0;
          end
          result_o.disk_write_bit   = shift_src[7];
          result_o.disk_write_valid = 1'b1;
          state_o.bit_shifter       = {shift_src[6:0], 1'b0};
          state_o.write_bits_left   = left_src - 4'd1;
        end
      end else if (lines[LnQ7:LnQ6] == QSelData) begin
        // deserialize, forcing a one after a long zero run
        if (item_i.disk_bit) begin
          state_o.zero_run_count = '0;
        end else if (zero_inc >= ZeroRunMax) begin
          state_o.zero_run_count = '0;
          rx_bit                 = 1'b1;
        end else begin
          state_o.zero_run_count = zero_inc;
        end
        shift_in = {state_i.bit_shifter[6:0], rx_bit};
        if (shift_in[7]) begin
          state_o.rd_hold_byte = shift_in;
          state_o.bit_shifter  = '0;
        end else begin
          state_o.bit_shifter = shift_in;
        end
      end
    end

    result_o.line_state = lines;
  end

endmodule

`default_nettype wire

// File: hw/rtl/fbsc_checker.sv
`default_nettype none

module fbsc_checker
  import fbsc_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  result_t res;
  assign res = result_t'(m_axis_tdata[$bits(result_t)-1:0]);

  // a written bit only goes out on a valid write cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.disk_write_bit |-> res.disk_write_valid)
    else $error("write bit without write valid");

  // a cell cannot both write and end the write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res.disk_write_valid && res.write_ended))
    else $error("write valid and write ended together");

  // writing needs q7 high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.disk_write_valid |-> res.line_state[LnQ7])
    else $error("bit written with q7 low");

  // strobe only when lstrb is high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.drive_strobe |-> res.line_state[LnLstrb])
    else $error("drive strobe with lstrb low");

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

endmodule

bind floppy_bit_serial_controller fbsc_checker u_fbsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
